FILE: design/keypad_code_lock_defines.svh
// Assertion macros used by the keypad code lock engine (kcl_engine).
// The macros expect signals named clk and rst in the module that uses them.
`ifndef KEYPAD_CODE_LOCK_DEFINES_SVH
`define KEYPAD_CODE_LOCK_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define KCL_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad_code_lock: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define KCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad_code_lock: next-cycle check failed");

`endif

FILE: design/kcl_pkg.sv
// Package for the keypad code lock: beat types, codes, register defaults.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package kcl_pkg;

  localparam int CODE_LENGTH_DEF = 4;

  localparam int KEY_W      = 4;
  localparam int EVENT_W    = 3;
  localparam int MODE_W     = 2;
  localparam int ENTERED_W  = 3;
  localparam int TIMEOUT_W  = 16;
  localparam int DEBOUNCE_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Beat kinds on the input channel.
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Keypad positions with a special role.
  localparam logic [KEY_W-1:0] KEY_ONE  = 4'd0;
  localparam logic [KEY_W-1:0] KEY_STAR = 4'd12;
  localparam logic [KEY_W-1:0] KEY_HASH = 4'd14;

  // Result events.
  localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EVENT_W-1:0] EV_GRANTED = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DENIED  = 3'd2;
  localparam logic [EVENT_W-1:0] EV_CHANGED = 3'd3;
  localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd4;

  // Mode codes as reported on the result channel.
  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHANGE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NEW    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd1;

  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 16'd10000;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd150;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_OPEN   = 4'b0010,
    ST_CHANGE = 4'b0100,
    ST_NEW    = 4'b1000
  } lock_state_t;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic [EVENT_W-1:0]   event_res;
    logic [MODE_W-1:0]    mode;
    logic [ENTERED_W-1:0] entered;
  } out_t;

  function automatic logic [MODE_W-1:0] mode_code(input lock_state_t st);
    logic [MODE_W-1:0] code;
    case (st)
      ST_IDLE:   code = MODE_IDLE;
      ST_OPEN:   code = MODE_OPEN;
      ST_CHANGE: code = MODE_CHANGE;
      ST_NEW:    code = MODE_NEW;
      default:   code = MODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: design/kcl_in_stage.sv
// Input register of the keypad code lock: holds one beat for the engine.
// Depends on kcl_pkg for the input beat type.
`default_nettype none

module kcl_in_stage (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire kcl_pkg::in_t in_data,
  output logic             item_valid,
  output kcl_pkg::in_t     item,
  input  wire logic        item_take
);

  // The register frees up in the same cycle the engine takes its beat.
  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/kcl_engine.sv
// Lock state machine, code storage, configuration registers and result register.
// Depends on kcl_pkg and the assertion macros in keypad_code_lock_defines.svh.
`default_nettype none
`include "keypad_code_lock_defines.svh"

module kcl_engine #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  input  wire kcl_pkg::in_t                   item,
  output logic                                item_take,
  input  wire logic                           cfg_we,
  input  wire logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output kcl_pkg::out_t                       out_data
);

  localparam int CW = $clog2(CODE_LENGTH + 1);

  typedef logic [CODE_LENGTH-1:0][kcl_pkg::KEY_W-1:0] code_t;

  kcl_pkg::lock_state_t lock_mode, lock_mode_next;
  logic [CW-1:0] key_count, key_count_next, key_filled;
  code_t entry_keys, entry_keys_next, entry_filled;
  code_t stored_code, stored_code_next;
  logic [kcl_pkg::TIMEOUT_W-1:0] entry_timer, entry_timer_next, timer_inc;
  logic [kcl_pkg::DEBOUNCE_W-1:0] since_press, since_press_next;
  logic [kcl_pkg::TIMEOUT_W-1:0] timeout_ticks;
  logic [kcl_pkg::DEBOUNCE_W-1:0] debounce_ticks;
  logic [kcl_pkg::EVENT_W-1:0] ev_res;
  logic code_match;

  assign item_take = item_valid && (!out_valid || out_ready);

  // The press being taken lands at the current fill position.
  always_comb begin
    for (int i = 0; i < CODE_LENGTH; i++) begin
      entry_filled[i] = (key_count == CW'(i)) ? item.key : entry_keys[i];
    end
  end

  assign key_filled = key_count + CW'(1);
  assign code_match = (entry_filled == stored_code);
  assign timer_inc  = (entry_timer == '1) ? entry_timer : entry_timer + 1'b1;

  always_comb begin
    lock_mode_next   = lock_mode;
    key_count_next   = key_count;
    entry_keys_next  = entry_keys;
    stored_code_next = stored_code;
    entry_timer_next = entry_timer;
    since_press_next = since_press;
    ev_res           = kcl_pkg::EV_NONE;
    if (item.op == kcl_pkg::OP_TICK) begin
      if (since_press != '1) begin
        since_press_next = since_press + 1'b1;
      end
      if (lock_mode == kcl_pkg::ST_NEW) begin
        entry_timer_next = timer_inc;
        if (timer_inc >= timeout_ticks) begin
          ev_res         = kcl_pkg::EV_TIMEOUT;
          lock_mode_next = kcl_pkg::ST_IDLE;
          key_count_next = '0;
        end
      end
    end else if (since_press >= debounce_ticks) begin
      since_press_next = '0;
      case (lock_mode)
        kcl_pkg::ST_IDLE: begin
          if (item.key == kcl_pkg::KEY_STAR) begin
            lock_mode_next = kcl_pkg::ST_OPEN;
            key_count_next = '0;
          end else if (item.key == kcl_pkg::KEY_HASH) begin
            lock_mode_next = kcl_pkg::ST_CHANGE;
            key_count_next = '0;
          end
        end
        kcl_pkg::ST_OPEN, kcl_pkg::ST_CHANGE, kcl_pkg::ST_NEW: begin
          entry_keys_next = entry_filled;
          key_count_next  = key_filled;
          if (key_filled == CW'(CODE_LENGTH)) begin
            key_count_next = '0;
            lock_mode_next = kcl_pkg::ST_IDLE;
            case (lock_mode)
              kcl_pkg::ST_OPEN: begin
                ev_res = code_match ? kcl_pkg::EV_GRANTED : kcl_pkg::EV_DENIED;
              end
              kcl_pkg::ST_CHANGE: begin
                if (code_match) begin
                  ev_res           = kcl_pkg::EV_GRANTED;
                  lock_mode_next   = kcl_pkg::ST_NEW;
                  entry_timer_next = '0;
                end else begin
                  ev_res = kcl_pkg::EV_DENIED;
                end
              end
              default: begin
                stored_code_next = entry_filled;
                ev_res           = kcl_pkg::EV_CHANGED;
              end
            endcase
          end
        end
        default: begin
          lock_mode_next = kcl_pkg::ST_IDLE;
          key_count_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_mode      <= kcl_pkg::ST_IDLE;
      key_count      <= '0;
      stored_code    <= {CODE_LENGTH{kcl_pkg::KEY_ONE}};
      entry_timer    <= '0;
      since_press    <= '0;
      timeout_ticks  <= kcl_pkg::TIMEOUT_RESET;
      debounce_ticks <= kcl_pkg::DEBOUNCE_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (item_take) begin
        lock_mode   <= lock_mode_next;
        key_count   <= key_count_next;
        stored_code <= stored_code_next;
        entry_timer <= entry_timer_next;
        since_press <= since_press_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we && cfg_index == kcl_pkg::CFG_TIMEOUT) begin
        timeout_ticks <= cfg_data[kcl_pkg::TIMEOUT_W-1:0];
      end
      if (cfg_we && cfg_index == kcl_pkg::CFG_DEBOUNCE) begin
        debounce_ticks <= cfg_data[kcl_pkg::DEBOUNCE_W-1:0];
      end
    end
  end

  // Entry keys and the result payload carry no reset.
  always_ff @(posedge clk) begin
    if (item_take) begin
      entry_keys         <= entry_keys_next;
      out_data.event_res <= ev_res;
      out_data.mode      <= kcl_pkg::mode_code(lock_mode_next);
      out_data.entered   <= kcl_pkg::ENTERED_W'(key_count_next);
    end
  end

  `KCL_ASSERT(a_count_bound, 1'b1, key_count < CW'(CODE_LENGTH))
  `KCL_ASSERT(a_idle_count, lock_mode == kcl_pkg::ST_IDLE, key_count == '0)
  `KCL_ASSERT_NEXT(a_timeout_idle, item_take && ev_res == kcl_pkg::EV_TIMEOUT, lock_mode == kcl_pkg::ST_IDLE && out_valid)
  `KCL_ASSERT_NEXT(a_code_written, item_take && ev_res == kcl_pkg::EV_CHANGED, stored_code == $past(entry_filled))
  `KCL_ASSERT_NEXT(a_code_hold, !(item_take && ev_res == kcl_pkg::EV_CHANGED), $stable(stored_code))

endmodule

`default_nettype wire

FILE: design/keypad_code_lock.sv
// Keypad code lock. A beat is held in the input register, then processed by the engine
// into the result register, from which it is offered until taken.
// Throughput: one beat per cycle, sustained, as long as results are taken; the
// state update for a beat is a single pass from the input register to the result.
// Reset is synchronous and active high: idle, counters and timers zero, stored code
// all '1' keys, timeout 10000 ticks, debounce 150 ticks; no clearing pass is needed.
`default_nettype none

module keypad_code_lock #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire kcl_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output kcl_pkg::out_t                       out_data,
  input  wire logic                           cfg_we,
  input  wire logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Each input beat is either a key press or a one-millisecond tick. The input
  // register holds one beat; the engine takes it whenever the result register is
  // empty or being drained, so the two sides are decoupled by one register each.
  logic         item_valid;
  logic         item_take;
  kcl_pkg::in_t item;

  kcl_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // The engine applies debounce, the lock state machine, the parallel code compare
  // and the entry timeout, and writes exactly one result beat per input beat.
  // Configuration writes go straight to its registers and apply to beats taken after the write.
  kcl_engine #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
